FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies; the checks are left out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMPQ_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define SMPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMPQ_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

FILE: rtl/smpq_pkg.sv
// Shared types and constants for the sorted max priority queue.
// No dependencies.
package smpq_pkg;

    localparam int CFG_W = 7;
    localparam int OCC_W = 7;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 7'd64;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef struct packed {
        logic ins;
        logic ext;
    } t_cell_ctl;

endpackage

FILE: rtl/smpq_ifs.sv
// Channel interfaces of the sorted max priority queue.
// Depends on smpq_pkg for the fixed field widths.
interface smpq_in_if import smpq_pkg::*; #(parameter int VALUE_WIDTH = 16);
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, operation, value, input ready);
    modport sink   (input valid, operation, value, output ready);
endinterface

interface smpq_out_if import smpq_pkg::*; #(parameter int VALUE_WIDTH = 16);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] max_value;
    logic                   extracted;
    logic                   empty_error;
    logic                   full_drop;
    logic [OCC_W-1:0]       occupancy;

    modport source (output valid, max_value, extracted, empty_error, full_drop, occupancy,
                    input ready);
    modport sink   (input valid, max_value, extracted, empty_error, full_drop, occupancy,
                    output ready);
endinterface

interface smpq_cfg_if import smpq_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/smpq_cell.sv
// One cell of the sorted chain: holds one entry, kept in descending order.
// Depends on smpq_pkg.
module smpq_cell import smpq_pkg::*; #(
    parameter int VALUE_WIDTH = 16,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [VALUE_WIDTH-1:0] i_prev_value,
    input  logic                   i_prev_keep,
    input  logic [VALUE_WIDTH-1:0] i_next_value,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic                   o_keep
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   w_occ;

    assign w_occ   = CNT_W'(INDEX) < i_count;
    assign o_keep  = w_occ && (r_value >= i_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        priority if (i_ctl.ext) begin
            n_value = i_next_value;
        end else if (i_ctl.ins && !o_keep) begin
            n_value = i_prev_keep ? i_value : i_prev_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: rtl/sorted_max_priority_queue_core.sv
// Sorted max priority queue, top level: chain of cells plus count and result register.
// Depends on smpq_pkg, smpq_ifs, smpq_cell and assert_macros.svh.
//
// Usage:
//   i_in  carries transactions: operation (insert or extract) and value.
//   o_out returns one result per transaction: max_value, extracted,
//         empty_error, full_drop and the occupancy after the transaction.
//   i_cfg writes the capacity register; it is always ready.
// Latency: a result is valid in the cycle after its transaction is taken.
// Throughput: one transaction per cycle while o_out is not stalled; every
//   cell compares against the broadcast value and shifts in the same clock,
//   whatever DEPTH is.
// i_in.ready is high while the result register is empty or being drained,
//   so a stalled o_out holds one result and stops new transactions.
// Reset empties the queue (count to zero) and sets capacity to 64; the
//   entries themselves are not cleared.
`include "assert_macros.svh"
module sorted_max_priority_queue_core import smpq_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smpq_in_if.sink    i_in,
    smpq_out_if.source o_out,
    smpq_cfg_if.sink   i_cfg
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CFG_W-1:0]       r_capacity;

    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_max_value;
    logic                   r_extracted;
    logic                   r_empty_error;
    logic                   r_full_drop;
    logic [OCC_W-1:0]       r_occupancy;

    logic                   w_in_acc;
    logic                   w_full;
    logic                   w_empty;
    logic [EXT_W-1:0]       w_count_ext;
    logic [EXT_W-1:0]       w_cap_ext;
    logic [EXT_W-1:0]       w_lim;
    logic [EXT_W-1:0]       w_next_ext;
    t_cell_ctl              w_ctl;

    logic [VALUE_WIDTH-1:0] w_cell_val  [DEPTH];
    logic                   w_cell_keep [DEPTH];

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign w_count_ext = EXT_W'(r_count);
    assign w_cap_ext   = EXT_W'(r_capacity);
    assign w_lim       = (w_cap_ext > EXT_W'(DEPTH)) ? EXT_W'(DEPTH) : w_cap_ext;
    assign w_full      = w_count_ext >= w_lim;
    assign w_empty     = (r_count == '0);

    assign w_ctl.ins = w_in_acc && (i_in.operation == OP_INSERT) && !w_full;
    assign w_ctl.ext = w_in_acc && (i_in.operation == OP_EXTRACT) && !w_empty;

    always_comb begin
        n_count = r_count;
        priority if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.ext) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_next_ext = EXT_W'(n_count);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        smpq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W),
            .INDEX       (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_value      (i_in.value),
            .i_prev_value ((g == 0) ? i_in.value : w_cell_val[(g == 0) ? 0 : g - 1]),
            .i_prev_keep  ((g == 0) ? 1'b1 : w_cell_keep[(g == 0) ? 0 : g - 1]),
            .i_next_value (w_cell_val[(g == DEPTH - 1) ? g : g + 1]),
            .o_value      (w_cell_val[g]),
            .o_keep       (w_cell_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_capacity  <= CAPACITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.data;
            end
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_max_value   <= w_ctl.ext ? w_cell_val[0] : '0;
            r_extracted   <= w_ctl.ext;
            r_empty_error <= (i_in.operation == OP_EXTRACT) && w_empty;
            r_full_drop   <= (i_in.operation == OP_INSERT) && w_full;
            r_occupancy   <= w_next_ext[OCC_W-1:0];
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.max_value   = r_max_value;
    assign o_out.extracted   = r_extracted;
    assign o_out.empty_error = r_empty_error;
    assign o_out.full_drop   = r_full_drop;
    assign o_out.occupancy   = r_occupancy;

    `SMPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `SMPQ_ASSERT(a_ins_count, i_clk, i_rst_n, w_ctl.ins |=> r_count == $past(r_count) + 1'b1, "insert did not grow count")
    `SMPQ_ASSERT(a_idle_count, i_clk, i_rst_n, !w_in_acc |=> $stable(r_count), "count moved without a transaction")
    `SMPQ_ASSERT(a_empty_flag, i_clk, i_rst_n, (w_in_acc && i_in.operation == OP_EXTRACT && w_empty) |=> (r_out_valid && r_empty_error && !r_extracted), "empty extract not flagged")
    `SMPQ_NEVER(a_ins_when_full, i_clk, i_rst_n, w_ctl.ins && w_full, "insert taken while full")

endmodule
